>>> rtl/semw_pkg.sv
// types and constants shared by the semaphore waiter queue
package semw_pkg;

	typedef enum logic [1:0] {
		OP_WAIT   = 2'd0,
		OP_SIGNAL = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_OPEN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_CLOSED  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_TAKE,
		S_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_PUSH,
		CELL_SHIFT,
		CELL_MARK,
		CELL_NARROW
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     head_take;
		logic     any_zero;
	} cell_ctl_t;

	localparam int COUNT_W   = 16;
	localparam int INIT_W    = 15;
	localparam int CFG_IDX_W = 1;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MODE = 1'b1;

endpackage

>>> rtl/counting_semaphore_waiter_queue_top.sv
// counting semaphore with a chain of cells holding the waiter queue
// open, wait, closed-error and fifo signal give a registered result in the cycle after start
// priority signal: one cell-wide search step per id bit and one take
// close with n waiters: n results back to back, one cell shift each
// these items can follow back to back; busy is high during search, take and drain
// reset: count 0, semaphore closed, queue empty, registers 0; no results in flight
module counting_semaphore_waiter_queue_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         mode,
	input  logic [ID_BITS-1:0]                 thread_id,
	input  logic                               cfg_we,
	input  logic [semw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [semw_pkg::INIT_W-1:0]        cfg_wdata,
	output logic                               done,
	output logic [1:0]                         status,
	output logic                               woken_valid,
	output logic [ID_BITS-1:0]                 woken_id,
	output logic                               woken_by_close,
	output logic                               last
);
	import semw_pkg::*;

	localparam int BIT_W = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

	state_t                      state_q, state_d;
	logic [BIT_W-1:0]            bit_q;
	logic signed [COUNT_W-1:0]   count_q, count_d;
	logic                        open_q, open_d;
	logic [INIT_W-1:0]           init_q;
	logic                        prio_q;

	logic                        done_q;
	status_t                     status_q;
	logic                        wv_q, wclose_q, last_q;
	logic [ID_BITS-1:0]          wid_q;

	logic                        res_fire;
	status_t                     res_status;
	logic                        res_wv, res_wclose, res_last;
	logic [ID_BITS-1:0]          res_wid;

	cell_ctl_t                   ctl;
	logic                        any_zero;
	logic [ID_BITS-1:0]          sel_or;

	logic [QUEUE_DEPTH-1:0]      valid_w;
	logic [QUEUE_DEPTH-1:0]      zero_w;
	logic [QUEUE_DEPTH:0]        hit_w;
	logic [ID_BITS-1:0]          id_w  [QUEUE_DEPTH];
	logic [ID_BITS-1:0]          sel_w [QUEUE_DEPTH];

	assign busy     = (state_q != S_IDLE);
	assign hit_w[0] = ctl.head_take;
	assign any_zero = |zero_w;

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_or = sel_or | sel_w[i];
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic               prev_v;
		logic               next_v;
		logic [ID_BITS-1:0] next_i;
		if (g == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_w[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_i = '0;
		end else begin : g_body
			assign next_v = valid_w[g+1];
			assign next_i = id_w[g+1];
		end
		semw_cell #(
			.ID_BITS (ID_BITS),
			.BIT_W   (BIT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.bit_sel    (bit_q),
			.push_id    (thread_id),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_id    (next_i),
			.hit_in     (hit_w[g]),
			.valid      (valid_w[g]),
			.id         (id_w[g]),
			.hit_out    (hit_w[g+1]),
			.zero_bit   (zero_w[g]),
			.sel_id     (sel_w[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && open_q) begin
					if (op_t'(mode) == OP_SIGNAL && count_q < 0 && valid_w[0] && prio_q) begin
						state_d = S_SEARCH;
					end else if (op_t'(mode) == OP_CLOSE && valid_w[1]) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_SEARCH: if (bit_q == '0) state_d = S_TAKE;
			S_TAKE:   state_d = S_IDLE;
			S_DRAIN:  if (!valid_w[1]) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs, cell control and count update
	always_comb begin
		ctl.op        = CELL_HOLD;
		ctl.head_take = 1'b0;
		ctl.any_zero  = any_zero;
		res_fire      = 1'b0;
		res_status    = ST_OK;
		res_wv        = 1'b0;
		res_wid       = '0;
		res_wclose    = 1'b0;
		res_last      = 1'b1;
		count_d       = count_q;
		open_d        = open_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					res_fire = 1'b1;
					if (op_t'(mode) == OP_OPEN) begin
						count_d = COUNT_W'({1'b0, init_q});
						open_d  = 1'b1;
						ctl.op  = CELL_CLEAR;
					end else if (!open_q) begin
						res_status = ST_CLOSED;
					end else begin
						case (op_t'(mode))
							OP_WAIT: begin
								if (count_q > 0) begin
									count_d = count_q - 16'sd1;
								end else if (valid_w[QUEUE_DEPTH-1]) begin
									res_status = ST_FULL;
								end else begin
									if (count_q != COUNT_MIN) count_d = count_q - 16'sd1;
									ctl.op     = CELL_PUSH;
									res_status = ST_BLOCKED;
								end
							end
							OP_SIGNAL: begin
								if (count_q != COUNT_MAX) count_d = count_q + 16'sd1;
								if (count_q < 0 && valid_w[0]) begin
									if (prio_q) begin
										ctl.op   = CELL_MARK;
										res_fire = 1'b0;
									end else begin
										ctl.op        = CELL_SHIFT;
										ctl.head_take = 1'b1;
										res_wv        = 1'b1;
										res_wid       = id_w[0];
									end
								end
							end
							OP_CLOSE: begin
								open_d = 1'b0;
								if (valid_w[0]) begin
									ctl.op        = CELL_SHIFT;
									ctl.head_take = 1'b1;
									res_wv        = 1'b1;
									res_wid       = id_w[0];
									res_wclose    = 1'b1;
									res_last      = !valid_w[1];
								end
							end
							default: res_status = ST_OK;
						endcase
					end
				end
			end
			S_SEARCH: ctl.op = CELL_NARROW;
			S_TAKE: begin
				ctl.op   = CELL_SHIFT;
				res_fire = 1'b1;
				res_wv   = 1'b1;
				res_wid  = sel_or;
			end
			S_DRAIN: begin
				ctl.op        = CELL_SHIFT;
				ctl.head_take = 1'b1;
				res_fire      = 1'b1;
				res_wv        = 1'b1;
				res_wid       = id_w[0];
				res_wclose    = 1'b1;
				res_last      = !valid_w[1];
			end
			default: ctl.op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_q   <= '0;
			count_q <= '0;
			open_q  <= 1'b0;
			init_q  <= '0;
			prio_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			open_q  <= open_d;
			done_q  <= res_fire;
			if (state_q == S_SEARCH) begin
				bit_q <= bit_q - 1'b1;
			end else begin
				bit_q <= BIT_W'(ID_BITS - 1);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL_COUNT: init_q <= cfg_wdata;
					CFG_PRIORITY_MODE: prio_q <= cfg_wdata[0];
					default:           prio_q <= prio_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= res_status;
		wv_q     <= res_wv;
		wid_q    <= res_wid;
		wclose_q <= res_wclose;
		last_q   <= res_last;
	end

	assign done           = done_q;
	assign status         = status_q;
	assign woken_valid    = wv_q;
	assign woken_id       = wid_q;
	assign woken_by_close = wclose_q;
	assign last           = last_q;

endmodule

>>> rtl/semw_cell.sv
// one queue cell: holds a waiter id, its valid bit and a search candidate flag
module semw_cell #(
	parameter int ID_BITS = 8,
	parameter int BIT_W   = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  semw_pkg::cell_ctl_t ctl,
	input  logic [BIT_W-1:0]    bit_sel,
	input  logic [ID_BITS-1:0]  push_id,
	input  logic                prev_valid,
	input  logic                next_valid,
	input  logic [ID_BITS-1:0]  next_id,
	input  logic                hit_in,
	output logic                valid,
	output logic [ID_BITS-1:0]  id,
	output logic                hit_out,
	output logic                zero_bit,
	output logic [ID_BITS-1:0]  sel_id
);
	import semw_pkg::*;

	logic               valid_q;
	logic               cand_q;
	logic [ID_BITS-1:0] id_q;
	logic               take;
	logic               load;

	assign take     = (ctl.op == CELL_SHIFT) && (hit_in || cand_q);
	assign load     = (ctl.op == CELL_PUSH) && !valid_q && prev_valid;
	assign hit_out  = hit_in || cand_q;
	assign zero_bit = cand_q && !id_q[bit_sel];
	assign sel_id   = (cand_q && !hit_in) ? id_q : '0;
	assign valid    = valid_q;
	assign id       = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_CLEAR:  valid_q <= 1'b0;
				CELL_PUSH:   if (load) valid_q <= 1'b1;
				CELL_SHIFT:  if (take) valid_q <= next_valid;
				CELL_MARK:   cand_q <= valid_q;
				CELL_NARROW: cand_q <= cand_q && !(ctl.any_zero && id_q[bit_sel]);
				default:     valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= push_id;
		end else if (take) begin
			id_q <= next_id;
		end
	end

endmodule

>>> rtl/semw_checker.sv
// port-level checks for the semaphore waiter queue and their bind
module semw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       done,
	input logic [1:0] status,
	input logic       woken_valid,
	input logic       woken_by_close,
	input logic       last
);
	import semw_pkg::*;

	// open and wait always answer on the next cycle
	a_open_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == OP_OPEN) |=> done && (status == ST_OK) && last)
		else $error("open item did not complete next cycle");

	a_wait_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == OP_WAIT) |=> done && last && !woken_valid)
		else $error("wait item did not complete next cycle");

	// close releases its waiters back to back
	a_drain_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_by_close && !last |=> done && woken_by_close && woken_valid)
		else $error("close drain broke off");

	a_close_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_by_close |-> woken_valid && (status == ST_OK))
		else $error("close release without a waiter");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> last && !woken_valid)
		else $error("error result released a waiter");

endmodule

bind counting_semaphore_waiter_queue_top semw_checker u_semw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.mode           (mode),
	.done           (done),
	.status         (status),
	.woken_valid    (woken_valid),
	.woken_by_close (woken_by_close),
	.last           (last)
);

>>> sim/counting_semaphore_waiter_queue_top_test.sv
// testbench for the semaphore waiter queue: directed and random operations, each result checked
module counting_semaphore_waiter_queue_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import semw_pkg::*;

	localparam int DEPTH = 16;
	localparam int ID_W  = 8;

	typedef struct {
		status_t         status;
		logic            wvalid;
		logic [ID_W-1:0] wid;
		logic            wclose;
		logic            last;
	} sem_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           mode = OP_WAIT;
	logic [ID_W-1:0]      thread_id = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INITIAL_COUNT;
	logic [INIT_W-1:0]    cfg_wdata = '0;
	logic                 done;
	logic [1:0]           status;
	logic                 woken_valid;
	logic [ID_W-1:0]      woken_id;
	logic                 woken_by_close;
	logic                 last;

	counting_semaphore_waiter_queue_top #(
		.QUEUE_DEPTH(DEPTH),
		.ID_BITS(ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.thread_id(thread_id),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.woken_valid(woken_valid),
		.woken_id(woken_id),
		.woken_by_close(woken_by_close),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted semaphore state and registers
	logic signed [COUNT_W-1:0] sem_count = '0;
	bit                        pred_open = 1'b0;
	logic [ID_W-1:0]           waiters[$];
	logic [INIT_W-1:0]         reg_init_count = '0;
	bit                        reg_priority = 1'b0;
	sem_result_t               pending_results[$];

	int  idle_pct = 0;
	bit  start_hi = 1'b0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  wakes_seen = 0;
	int  close_wakes_seen = 0;
	int  blocked_seen = 0;
	int  full_seen = 0;
	int  closed_err_seen = 0;
	int  mismatch_count = 0;

	task automatic expect_result(status_t st, logic wv, logic [ID_W-1:0] wid, logic wc,
		logic lst);
		sem_result_t r;
		r.status = st;
		r.wvalid = wv;
		r.wid    = wid;
		r.wclose = wc;
		r.last   = lst;
		pending_results.push_back(r);
	endtask

	task automatic apply_sem_op(op_t op, logic [ID_W-1:0] tid);
		int  pos;
		bit  was_neg;
		int  n;
		if (op == OP_OPEN) begin
			sem_count = signed'({1'b0, reg_init_count});
			pred_open = 1'b1;
			waiters.delete();
			expect_result(ST_OK, 1'b0, '0, 1'b0, 1'b1);
		end else if (!pred_open) begin
			expect_result(ST_CLOSED, 1'b0, '0, 1'b0, 1'b1);
		end else begin
			case (op)
				OP_WAIT: begin
					if (sem_count > 0) begin
						sem_count = sem_count - 16'sd1;
						expect_result(ST_OK, 1'b0, '0, 1'b0, 1'b1);
					end else if (waiters.size() >= DEPTH) begin
						expect_result(ST_FULL, 1'b0, '0, 1'b0, 1'b1);
					end else begin
						if (sem_count != COUNT_MIN)
							sem_count = sem_count - 16'sd1;
						waiters.push_back(tid);
						expect_result(ST_BLOCKED, 1'b0, '0, 1'b0, 1'b1);
					end
				end
				OP_SIGNAL: begin
					was_neg = (sem_count < 0);
					if (sem_count != COUNT_MAX)
						sem_count = sem_count + 16'sd1;
					if (was_neg && waiters.size() > 0) begin
						pos = 0;
						if (reg_priority) begin
							// strict less-than keeps the oldest among equal ids
							for (int i = 1; i < waiters.size(); i++)
								if (waiters[i] < waiters[pos])
									pos = i;
						end
						expect_result(ST_OK, 1'b1, waiters[pos], 1'b0, 1'b1);
						waiters.delete(pos);
					end else begin
						expect_result(ST_OK, 1'b0, '0, 1'b0, 1'b1);
					end
				end
				default: begin
					pred_open = 1'b0;
					n = waiters.size();
					if (n == 0) begin
						expect_result(ST_OK, 1'b0, '0, 1'b0, 1'b1);
					end else begin
						for (int i = 0; i < n; i++)
							expect_result(ST_OK, 1'b1, waiters[i], 1'b1, i == n - 1);
						waiters.delete();
					end
				end
			endcase
		end
	endtask

	task automatic send_item(op_t op, logic [ID_W-1:0] tid);
		int gap;
		start <= 1'b1;
		mode <= op;
		thread_id <= tid;
		do
			@(posedge clk);
		while (busy);
		apply_sem_op(op, tid);
		items_sent++;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			start_hi = 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			start_hi = 1'b1;
		end
	endtask

	task automatic settle();
		if (start_hi) begin
			start <= 1'b0;
			start_hi = 1'b0;
		end
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [INIT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INITIAL_COUNT)
			reg_init_count = val;
		else
			reg_priority = val[0];
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		sem_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (woken_valid)
				wakes_seen++;
			if (woken_valid && woken_by_close)
				close_wakes_seen++;
			if (status == ST_BLOCKED)
				blocked_seen++;
			if (status == ST_FULL)
				full_seen++;
			if (status == ST_CLOSED)
				closed_err_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no item waiting: status %0d woken_id %0d", status, woken_id);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (woken_valid !== want.wvalid) begin
					$error("woken_valid: expected %0d, got %0d", want.wvalid, woken_valid);
					mismatch_count++;
				end
				if (woken_id !== want.wid) begin
					$error("woken_id: expected %0d, got %0d", want.wid, woken_id);
					mismatch_count++;
				end
				if (woken_by_close !== want.wclose) begin
					$error("woken_by_close: expected %0d, got %0d", want.wclose,
						woken_by_close);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_closed_ops();
		send_item(OP_WAIT, 8'd0);
		send_item(OP_SIGNAL, 8'd255);
		send_item(OP_CLOSE, 8'hAA);
		settle();
	endtask

	task automatic test_fifo_wake();
		write_reg(CFG_PRIORITY_MODE, '0);
		write_reg(CFG_INITIAL_COUNT, 15'd2);
		send_item(OP_OPEN, 8'd0);
		send_item(OP_WAIT, 8'd5);
		send_item(OP_WAIT, 8'd9);
		send_item(OP_WAIT, 8'd200);
		send_item(OP_WAIT, 8'd3);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_SIGNAL, 8'd0);
		// close with empty queue, then a wait on the closed semaphore
		send_item(OP_CLOSE, 8'd0);
		send_item(OP_WAIT, 8'd1);
		settle();
	endtask

	task automatic test_priority_wake();
		write_reg(CFG_PRIORITY_MODE, 15'd1);
		write_reg(CFG_INITIAL_COUNT, '0);
		send_item(OP_OPEN, 8'd0);
		send_item(OP_WAIT, 8'd7);
		send_item(OP_WAIT, 8'd2);
		send_item(OP_WAIT, 8'd255);
		send_item(OP_WAIT, 8'd2);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_SIGNAL, 8'd0);
		// reopen drops the waiters left
		send_item(OP_OPEN, 8'd0);
		send_item(OP_WAIT, 8'd0);
		send_item(OP_WAIT, 8'd128);
		send_item(OP_CLOSE, 8'd0);
		settle();
	endtask

	task automatic test_queue_full();
		write_reg(CFG_PRIORITY_MODE, '0);
		write_reg(CFG_INITIAL_COUNT, '0);
		send_item(OP_OPEN, 8'd0);
		repeat (DEPTH) send_item(OP_WAIT, 8'($urandom_range(255)));
		send_item(OP_WAIT, 8'd77);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_WAIT, 8'd254);
		send_item(OP_CLOSE, 8'd0);
		settle();
	endtask

	task automatic test_count_limits();
		write_reg(CFG_INITIAL_COUNT, 15'h7FFF);
		send_item(OP_OPEN, 8'd0);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_WAIT, 8'd1);
		send_item(OP_SIGNAL, 8'd0);
		settle();
		write_reg(CFG_INITIAL_COUNT, '0);
		send_item(OP_OPEN, 8'd0);
		send_item(OP_SIGNAL, 8'd0);
		send_item(OP_WAIT, 8'd10);
		send_item(OP_WAIT, 8'd11);
		send_item(OP_SIGNAL, 8'd0);
		settle();
	endtask

	task automatic test_random(int pct, int blocks, int per_block);
		int               r;
		op_t              op;
		logic [ID_W-1:0]  tid;
		logic [INIT_W-1:0] init_val;
		idle_pct = pct;
		for (int b = 0; b < blocks; b++) begin
			settle();
			case ($urandom_range(5))
				0: init_val = '0;
				1: init_val = 15'h7FFF;
				2: init_val = 15'($urandom_range(32767));
				default: init_val = 15'($urandom_range(4));
			endcase
			write_reg(CFG_INITIAL_COUNT, init_val);
			write_reg(CFG_PRIORITY_MODE, 15'($urandom_range(1)));
			send_item(OP_OPEN, 8'($urandom_range(255)));
			for (int i = 0; i < per_block; i++) begin
				r = $urandom_range(99);
				// a closed semaphore is usually reopened soon
				if (!pred_open && r < 60)
					op = OP_OPEN;
				else if (r < 4)
					op = OP_OPEN;
				else if (r < 9)
					op = OP_CLOSE;
				else if (r < 58)
					op = OP_WAIT;
				else
					op = OP_SIGNAL;
				if ($urandom_range(1))
					tid = 8'($urandom_range(255));
				else
					tid = 8'($urandom_range(7));
				send_item(op, tid);
			end
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_closed_ops();
		test_fifo_wake();
		test_priority_wake();
		test_queue_full();
		test_count_limits();
		test_random(30, 3, 19);
		test_random(75, 3, 19);
		test_random(0, 3, 19);
		repeat (ID_W + 4) @(posedge clk);
		$display("covered %0d items, %0d results, %0d wakeups (%0d from close)",
			items_sent, results_seen, wakes_seen, close_wakes_seen);
		$display("blocked %0d, queue full %0d, closed errors %0d, mismatches %0d",
			blocked_seen, full_seen, closed_err_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout waiting for results");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> counting_semaphore_waiter_queue_top.f
rtl/semw_pkg.sv
rtl/semw_cell.sv
rtl/counting_semaphore_waiter_queue_top.sv
rtl/semw_checker.sv
sim/counting_semaphore_waiter_queue_top_test.sv
